// ===== sv/tfs_pkg.sv =====
package tfs_pkg;

    localparam int NumValues    = 9;
    localparam int NumAttValues = 6;

    localparam logic [7:0] SyncByte0   = 8'hA5;
    localparam logic [7:0] SyncByte1   = 8'h5A;
    localparam logic [7:0] LenAtt      = 8'd16;
    localparam logic [7:0] LenMotion   = 8'd22;
    localparam logic [7:0] TypeAtt     = 8'hA1;
    localparam logic [7:0] TypeMotion  = 8'hA2;
    localparam logic [7:0] TailByte    = 8'hAA;

    // byte positions inside a frame
    localparam logic [4:0] PosSync1    = 5'd1;
    localparam logic [4:0] PosLen      = 5'd2;
    localparam logic [4:0] PosType     = 5'd3;
    localparam logic [4:0] PosData     = 5'd4;
    localparam logic [4:0] PosLastAtt  = 5'd17;
    localparam logic [4:0] PosLastMot  = 5'd23;

    typedef logic [15:0] word_t;

    typedef struct packed {
        logic                          kind;
        logic [7:0]                    checksum;
        logic [NumValues-1:0][15:0]    words;
    } frame_t;

    // two's complement to sign-magnitude, most negative value saturates
    function automatic word_t to_sign_mag(input word_t raw);
        word_t mag;
        begin
            mag = 16'h0000 - raw;
            if (!raw[15]) begin
                to_sign_mag = raw;
            end else if (raw == 16'h8000) begin
                to_sign_mag = 16'hFFFF;
            end else begin
                to_sign_mag = {1'b1, mag[14:0]};
            end
        end
    endfunction

endpackage

// ===== sv/tfs_lane.sv =====
module tfs_lane (
    input  logic               aclk,
    input  logic               load,
    input  logic               used,
    input  logic signed [15:0] value,
    output tfs_pkg::word_t     sm_word,
    output logic [7:0]         byte_sum
);

    tfs_pkg::word_t sm_next;
    tfs_pkg::word_t sm_reg;
    logic [7:0]     sum_next;
    logic [7:0]     sum_reg;

    // unused lanes latch zero, which also adds nothing to the checksum
    always_comb begin
        sm_next  = used ? tfs_pkg::to_sign_mag(tfs_pkg::word_t'(value)) : '0;
        sum_next = sm_next[15:8] + sm_next[7:0];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sm_reg  <= sm_next;
            sum_reg <= sum_next;
        end
    end

    assign sm_word  = sm_reg;
    assign byte_sum = sum_reg;

endmodule

// ===== sv/tfs_merge.sv =====
module tfs_merge (
    input  logic                                   kind,
    input  logic [tfs_pkg::NumValues-1:0][15:0]    words,
    input  logic [tfs_pkg::NumValues-1:0][7:0]     lane_sums,
    output tfs_pkg::frame_t                        frame
);

    logic [7:0] header_sum;
    logic [7:0] group0;
    logic [7:0] group1;
    logic [7:0] group2;

    // adder tree over the lane partial sums
    always_comb begin
        header_sum = kind ? (tfs_pkg::LenMotion + tfs_pkg::TypeMotion)
                          : (tfs_pkg::LenAtt + tfs_pkg::TypeAtt);
        group0 = lane_sums[0] + lane_sums[1] + lane_sums[2];
        group1 = lane_sums[3] + lane_sums[4] + lane_sums[5];
        group2 = lane_sums[6] + lane_sums[7] + lane_sums[8];
        frame.kind     = kind;
        frame.words    = words;
        frame.checksum = (header_sum + group0) + (group1 + group2);
    end

endmodule

// ===== sv/tfs_ser.sv =====
module tfs_ser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load_valid,
    input  tfs_pkg::frame_t frame_in,
    output logic            load_ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // out_byte[7:0]
    output logic            m_tlast
);

    logic            busy_reg;
    logic            busy_next;
    logic [4:0]      pos_reg;
    logic [4:0]      pos_next;
    tfs_pkg::frame_t frame_reg;
    logic [4:0]      last_pos;
    logic [4:0]      data_off;
    logic [3:0]      word_idx;
    tfs_pkg::word_t  word_sel;
    logic            take;

    assign last_pos   = frame_reg.kind ? tfs_pkg::PosLastMot : tfs_pkg::PosLastAtt;
    assign take       = busy_reg && m_tready;
    assign load_ready = !busy_reg || (m_tready && (pos_reg == last_pos));
    assign data_off   = pos_reg - tfs_pkg::PosData;
    assign word_idx   = data_off[4:1];

    always_comb begin
        word_sel = '0;
        for (int i = 0; i < tfs_pkg::NumValues; i++) begin
            if (word_idx == 4'(i)) word_sel = frame_reg.words[i];
        end
    end

    always_comb begin
        if (pos_reg == last_pos) begin
            m_tdata = tfs_pkg::TailByte;
        end else if (pos_reg == last_pos - 5'd1) begin
            m_tdata = frame_reg.checksum;
        end else if (pos_reg >= tfs_pkg::PosData) begin
            m_tdata = data_off[0] ? word_sel[7:0] : word_sel[15:8];
        end else if (pos_reg == tfs_pkg::PosType) begin
            m_tdata = frame_reg.kind ? tfs_pkg::TypeMotion : tfs_pkg::TypeAtt;
        end else if (pos_reg == tfs_pkg::PosLen) begin
            m_tdata = frame_reg.kind ? tfs_pkg::LenMotion : tfs_pkg::LenAtt;
        end else if (pos_reg == tfs_pkg::PosSync1) begin
            m_tdata = tfs_pkg::SyncByte1;
        end else begin
            m_tdata = tfs_pkg::SyncByte0;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = (pos_reg == last_pos);

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load_ready) begin
            busy_next = load_valid;
            pos_next  = '0;
        end else if (take) begin
            pos_next = pos_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ready && load_valid) frame_reg <= frame_in;
    end

    a_last_is_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == tfs_pkg::TailByte)
        else $error("tlast on a byte other than the tail");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pos_reg <= tfs_pkg::PosLastMot)
        else $error("byte position past the longest frame");

    a_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast && load_valid
        |=> m_tvalid && m_tdata == tfs_pkg::SyncByte0)
        else $error("queued frame did not start right after the tail");

    a_idle_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> pos_reg == 5'd0)
        else $error("byte position not cleared while idle");

endmodule

// ===== sv/telemetry_frame_serializer_core.sv =====
// Telemetry frame serializer: each input transaction is one report request (tuser
// selects attitude, 6 values, or motion, 9 values) and comes out as an 18- or 24-byte
// frame, one byte per output transaction: A5 5A, length, type, each value as two
// big-endian sign-magnitude bytes, an additive checksum, then AA with tlast set.
// Nine conversion lanes turn the values to sign-magnitude and form per-lane byte sums
// in one registered stage; an adder tree merges those into the checksum as the frame
// is handed to the byte serializer. A request is taken while the previous frame is
// still going out, so frames leave back to back, at a rate set by the output port,
// which moves one byte per cycle while m_tready is high. A request passes the lane
// registers, then the serializer's frame register, before its first byte goes out.
module telemetry_frame_serializer_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // value_0 .. value_8, 16 bits each, value_0 lowest
    input  logic [0:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // out_byte
    output logic         m_tlast
);

    // lane stage control
    logic                                    lane_valid_reg;
    logic                                    lane_valid_next;
    logic                                    kind_reg;
    logic                                    s_take;
    logic                                    ser_ready;
    logic [tfs_pkg::NumValues-1:0][15:0]     lane_words;
    logic [tfs_pkg::NumValues-1:0][7:0]      lane_sums;
    tfs_pkg::frame_t                         frame;

    // lane stage frees up when its request moves into the serializer
    assign s_tready = !lane_valid_reg || ser_ready;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        lane_valid_next = lane_valid_reg;
        if (s_take) begin
            lane_valid_next = 1'b1;
        end else if (ser_ready) begin
            lane_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg <= 1'b0;
        end else begin
            lane_valid_reg <= lane_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) kind_reg <= s_tuser[0];
    end

    // one conversion lane per value; the last three only run for motion frames
    for (genvar g = 0; g < tfs_pkg::NumValues; g++) begin : g_lane
        tfs_lane u_lane (
            .aclk     (aclk),
            .load     (s_take),
            .used     ((g < tfs_pkg::NumAttValues) || s_tuser[0]),
            .value    (s_tdata[g*16 +: 16]),
            .sm_word  (lane_words[g]),
            .byte_sum (lane_sums[g])
        );
    end

    // checksum merge across lanes
    tfs_merge u_merge (
        .kind      (kind_reg),
        .words     (lane_words),
        .lane_sums (lane_sums),
        .frame     (frame)
    );

    // byte serializer with its own frame register
    tfs_ser u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (lane_valid_reg),
        .frame_in   (frame),
        .load_ready (ser_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
